FILE: hdl/tremolo_pulse_pair_sequencer_defines.svh
// Assertion macros for the tremolo pulse pair sequencer checker.
`ifndef TREMOLO_PULSE_PAIR_SEQUENCER_DEFINES_SVH
`define TREMOLO_PULSE_PAIR_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TPPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpps checker: property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TPPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpps checker: property failed");

`endif

FILE: hdl/tpps_pkg.sv
// Types and constants shared by the tremolo pulse pair sequencer files.
`timescale 1ns / 1ps
`default_nettype none

package tpps_pkg;

    localparam int AMP_W      = 8;
    localparam int DUR_W      = 8;
    localparam int DUR_INT_W  = 10;
    localparam int PROD_W     = 16;
    localparam int MUL_W      = 32;
    localparam int ARITH_W    = 12;
    localparam int VAR_W      = 8;
    localparam int REP_W      = 8;
    localparam int STEP_W     = 8;
    localparam int HOLD_W     = 6;
    localparam int TREM_W     = 8;
    localparam int RATE_W     = 6;
    localparam int HCNT_W     = 4;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // floor(p / 100) for p < 65536 as ((p >> 2) * 20972) >> 19
    localparam logic [PROD_W-1:0] DIV100_MUL   = 16'd20972;
    localparam int                DIV100_SHIFT = 19;

    localparam logic [STEP_W-1:0] RAMP_PAIRS = 8'd14;
    localparam logic [STEP_W-1:0] RAMP_LAST  = 8'd13;

    localparam logic signed [ARITH_W-1:0] RAMP_DELTA = 12'sd12;
    localparam logic signed [ARITH_W-1:0] AMP_MIN    = 12'sd16;
    localparam logic signed [ARITH_W-1:0] AMP_MAX    = 12'sd239;
    localparam logic signed [ARITH_W-1:0] DUR_MIN    = 12'sd6;
    localparam logic signed [ARITH_W-1:0] DUR_MAX    = 12'sd239;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ATTACK,
        PH_PLATEAU,
        PH_RELEASE
    } phase_t;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        REG_AMP_VAR_A,
        REG_AMP_VAR_B,
        REG_DUR_VAR_A,
        REG_DUR_VAR_B,
        REG_REPEAT_COUNT,
        REG_PLATEAU_STEPS,
        REG_TREMOLO_RATE,
        REG_HOLD_COUNT
    } cfg_reg_t;

    // Sequencer position
    typedef struct packed {
        phase_t              phase;
        logic [REP_W-1:0]    rep;
        logic [STEP_W-1:0]   step;
        logic [HOLD_W-1:0]   hold;
        logic [TREM_W-1:0]   trem;
    } seq_t;

endpackage

`default_nettype wire

FILE: hdl/tpps_if.sv
// Valid/ready channel interfaces for the command and result words.
`timescale 1ns / 1ps
`default_nettype none

interface tpps_cmd_if import tpps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [AMP_W-1:0] start_amp_a;
    logic [AMP_W-1:0] start_amp_b;
    logic [DUR_W-1:0] start_dur_a;
    logic [DUR_W-1:0] start_dur_b;
    logic [DUR_W-1:0] scale_percent;

    modport source (
        output valid, kind, start_amp_a, start_amp_b, start_dur_a, start_dur_b,
               scale_percent,
        input  ready
    );
    modport sink (
        input  valid, kind, start_amp_a, start_amp_b, start_dur_a, start_dur_b,
               scale_percent,
        output ready
    );
endinterface

interface tpps_res_if import tpps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AMP_W-1:0] amplitude;
    logic [DUR_W-1:0] duration;
    logic             last;

    modport source (
        output valid, amplitude, duration, last,
        input  ready
    );
    modport sink (
        input  valid, amplitude, duration, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/tremolo_pulse_pair_sequencer.sv
// Tremolo pulse pair sequencer: input register, sequencer step logic, result register.
// A tick word goes into the input register, then its result word into the result register.
// Throughput: one word per cycle while no result word stalls; while a result word waits,
// the input register holds one word. The only multiply chain (duration * percent, then the
// divide by 100) is split by the input register. Reset: rst_n asynchronous, active low;
// phase goes idle, registers take their reset values, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tremolo_pulse_pair_sequencer import tpps_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    tpps_cmd_if.sink              cmd,
    tpps_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Configuration registers (APB, zero wait state)
    // ---------------------------------------------------------------
    logic [VAR_W-1:0]  amp_var_a_reg, amp_var_b_reg, dur_var_a_reg, dur_var_b_reg;
    logic [REP_W-1:0]  repeat_count_reg;
    logic [STEP_W-1:0] plateau_steps_reg;
    logic [RATE_W-1:0] tremolo_rate_reg;
    logic [HCNT_W-1:0] hold_count_reg;
    logic              cfg_we;
    cfg_reg_t          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_var_a_reg     <= '0;
            amp_var_b_reg     <= '0;
            dur_var_a_reg     <= '0;
            dur_var_b_reg     <= '0;
            repeat_count_reg  <= REP_W'(1);
            plateau_steps_reg <= '0;
            tremolo_rate_reg  <= '0;
            hold_count_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_AMP_VAR_A:     amp_var_a_reg     <= pwdata[VAR_W-1:0];
                REG_AMP_VAR_B:     amp_var_b_reg     <= pwdata[VAR_W-1:0];
                REG_DUR_VAR_A:     dur_var_a_reg     <= pwdata[VAR_W-1:0];
                REG_DUR_VAR_B:     dur_var_b_reg     <= pwdata[VAR_W-1:0];
                REG_REPEAT_COUNT:  repeat_count_reg  <= pwdata[REP_W-1:0];
                REG_PLATEAU_STEPS: plateau_steps_reg <= pwdata[STEP_W-1:0];
                REG_TREMOLO_RATE:  tremolo_rate_reg  <= pwdata[RATE_W-1:0];
                REG_HOLD_COUNT:    hold_count_reg    <= pwdata[HCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_AMP_VAR_A:     prdata = CFG_DATA_W'(amp_var_a_reg);
            REG_AMP_VAR_B:     prdata = CFG_DATA_W'(amp_var_b_reg);
            REG_DUR_VAR_A:     prdata = CFG_DATA_W'(dur_var_a_reg);
            REG_DUR_VAR_B:     prdata = CFG_DATA_W'(dur_var_b_reg);
            REG_REPEAT_COUNT:  prdata = CFG_DATA_W'(repeat_count_reg);
            REG_PLATEAU_STEPS: prdata = CFG_DATA_W'(plateau_steps_reg);
            REG_TREMOLO_RATE:  prdata = CFG_DATA_W'(tremolo_rate_reg);
            REG_HOLD_COUNT:    prdata = CFG_DATA_W'(hold_count_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input register. The duration * percent products are formed on the
    // way in; the divide by 100 follows in the step logic.
    // ---------------------------------------------------------------
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_kind_reg;
    logic [AMP_W-1:0]  s1_amp_a_reg, s1_amp_b_reg;
    logic [PROD_W-1:0] s1_prod_a_reg, s1_prod_b_reg;
    logic              s1_take;
    logic              out_free;
    logic              cmd_fire;

    assign out_free  = !res.valid || res.ready;
    assign s1_take   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || s1_take;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        if (cmd_fire)
            s1_valid_next = 1'b1;
        else if (s1_take)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_kind_reg   <= cmd.kind;
            s1_amp_a_reg  <= cmd.start_amp_a;
            s1_amp_b_reg  <= cmd.start_amp_b;
            s1_prod_a_reg <= PROD_W'(cmd.start_dur_a) * PROD_W'(cmd.scale_percent);
            s1_prod_b_reg <= PROD_W'(cmd.start_dur_b) * PROD_W'(cmd.scale_percent);
        end
    end

    // quarter the product, then divide by 25 via reciprocal; exact for every 16-bit product
    logic [MUL_W-1:0]     div_a, div_b;
    logic [DUR_INT_W-1:0] quo_a, quo_b;

    assign div_a = MUL_W'(s1_prod_a_reg[PROD_W-1:2]) * MUL_W'(DIV100_MUL);
    assign div_b = MUL_W'(s1_prod_b_reg[PROD_W-1:2]) * MUL_W'(DIV100_MUL);
    assign quo_a = div_a[DIV100_SHIFT +: DUR_INT_W];
    assign quo_b = div_b[DIV100_SHIFT +: DUR_INT_W];

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    seq_t                 seq_reg, seq_next, cur, upd;
    logic [AMP_W-1:0]     amp_a_reg, amp_b_reg, amp_a_next, amp_b_next;
    logic [DUR_INT_W-1:0] dur_a_reg, dur_b_reg, dur_a_next, dur_b_next;
    logic [HOLD_W-1:0]    hold_lim;

    // the two words of the main pair plus the hold pairs of one plateau step
    assign hold_lim = HOLD_W'({1'b0, hold_count_reg, 1'b0}) + HOLD_W'(2);

    function automatic logic signed [ARITH_W-1:0] sx(input logic [VAR_W-1:0] v);
        sx = $signed({{(ARITH_W-VAR_W){v[VAR_W-1]}}, v});
    endfunction

    function automatic logic [AMP_W-1:0] clamp(
        input logic signed [ARITH_W-1:0] v,
        input logic signed [ARITH_W-1:0] lo,
        input logic signed [ARITH_W-1:0] hi
    );
        logic signed [ARITH_W-1:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        clamp = r[AMP_W-1:0];
    endfunction

    // One phase transition, if the position has run past its phase.
    function automatic seq_t settle_once(
        input seq_t              s,
        input logic [STEP_W-1:0] ps,
        input logic [HOLD_W-1:0] lim
    );
        seq_t r;
        r = s;
        case (s.phase)
            PH_ATTACK:
            begin
                if (s.step >= RAMP_PAIRS)
                begin
                    r.phase = PH_PLATEAU;
                    r.step  = '0;
                    r.hold  = '0;
                    r.trem  = '0;
                end
            end
            PH_PLATEAU:
            begin
                if (s.hold >= lim)
                begin
                    r.step = s.step + STEP_W'(1);
                    r.hold = '0;
                end
                else if (s.step >= ps)
                begin
                    r.phase = PH_RELEASE;
                    r.step  = '0;
                    r.hold  = '0;
                end
            end
            PH_RELEASE:
            begin
                if (s.step >= RAMP_PAIRS)
                begin
                    if (s.rep != '0)
                        r.rep = s.rep - REP_W'(1);
                    r.step  = '0;
                    r.phase = (r.rep == '0) ? PH_IDLE : PH_ATTACK;
                end
            end
            default: ;
        endcase
        settle_once = r;
    endfunction

    // at most two transitions chain; the third pass is margin
    function automatic seq_t settle(
        input seq_t              s,
        input logic [STEP_W-1:0] ps,
        input logic [HOLD_W-1:0] lim
    );
        settle = settle_once(settle_once(settle_once(s, ps, lim), ps, lim), ps, lim);
    endfunction

    // ---------------------------------------------------------------
    // Plateau step: tremolo direction, variations, clamps
    // ---------------------------------------------------------------
    logic                      trem_down;
    logic                      trem_wrap;
    logic signed [ARITH_W-1:0] dva, dvb, ava, avb;
    logic [AMP_W-1:0]          pl_amp_a, pl_amp_b;
    logic [DUR_W-1:0]          pl_dur_a, pl_dur_b;

    assign trem_down = cur.trem < TREM_W'({tremolo_rate_reg, 1'b0});
    assign trem_wrap = ({1'b0, cur.trem} + 9'd1) >= {1'b0, tremolo_rate_reg, 2'b00};

    // down: durations gain, amplitudes lose; otherwise the reverse
    assign dva = trem_down ? sx(dur_var_a_reg) : -sx(dur_var_a_reg);
    assign dvb = trem_down ? sx(dur_var_b_reg) : -sx(dur_var_b_reg);
    assign ava = trem_down ? -sx(amp_var_a_reg) : sx(amp_var_a_reg);
    assign avb = trem_down ? -sx(amp_var_b_reg) : sx(amp_var_b_reg);

    assign pl_dur_a = clamp($signed(ARITH_W'(dur_a_reg)) + dva, DUR_MIN, DUR_MAX);
    assign pl_dur_b = clamp($signed(ARITH_W'(dur_b_reg)) + dvb, DUR_MIN, DUR_MAX);
    assign pl_amp_a = clamp($signed(ARITH_W'(amp_a_reg)) + ava, AMP_MIN, AMP_MAX);
    assign pl_amp_b = clamp($signed(ARITH_W'(amp_b_reg)) + avb, AMP_MIN, AMP_MAX);

    // ---------------------------------------------------------------
    // Attack / release ramp: channel 0 up, channel 1 down (mirrored on release)
    // ---------------------------------------------------------------
    logic                      ramp_rel;
    logic signed [ARITH_W-1:0] ramp_da, ramp_db;
    logic [AMP_W-1:0]          rp_amp_a, rp_amp_b;

    assign ramp_rel = (cur.phase == PH_RELEASE);
    assign ramp_da  = ramp_rel ? -RAMP_DELTA : RAMP_DELTA;
    assign ramp_db  = ramp_rel ? RAMP_DELTA : -RAMP_DELTA;
    assign rp_amp_a = clamp($signed(ARITH_W'(amp_a_reg)) + ramp_da, AMP_MIN, AMP_MAX);
    assign rp_amp_b = clamp($signed(ARITH_W'(amp_b_reg)) + ramp_db, AMP_MIN, AMP_MAX);

    // ---------------------------------------------------------------
    // Step logic
    // ---------------------------------------------------------------
    logic             emit;
    logic [AMP_W-1:0] out_amp;
    logic [DUR_W-1:0] out_dur;
    logic             out_last;

    always_comb
    begin
        // registers may have changed since the last tick: settle first
        cur        = settle(seq_reg, plateau_steps_reg, hold_lim);
        upd        = cur;
        seq_next   = seq_reg;
        amp_a_next = amp_a_reg;
        amp_b_next = amp_b_reg;
        dur_a_next = dur_a_reg;
        dur_b_next = dur_b_reg;
        emit       = 1'b0;
        out_amp    = amp_a_reg;
        out_dur    = dur_a_reg[DUR_W-1:0];
        out_last   = 1'b0;

        if (s1_take)
        begin
            if (s1_kind_reg == KIND_START)
            begin
                amp_a_next     = s1_amp_a_reg;
                amp_b_next     = s1_amp_b_reg;
                dur_a_next     = quo_a;
                dur_b_next     = quo_b;
                seq_next.rep   = repeat_count_reg;
                seq_next.step  = '0;
                seq_next.hold  = '0;
                seq_next.trem  = '0;
                seq_next.phase = (repeat_count_reg == '0) ? PH_IDLE : PH_ATTACK;
            end
            else if (cur.phase == PH_IDLE)
            begin
                seq_next = cur;
            end
            else
            begin
                emit = 1'b1;
                if (cur.phase == PH_PLATEAU)
                begin
                    if (cur.hold == '0)
                    begin
                        amp_a_next = pl_amp_a;
                        amp_b_next = pl_amp_b;
                        dur_a_next = DUR_INT_W'(pl_dur_a);
                        dur_b_next = DUR_INT_W'(pl_dur_b);
                        upd.trem   = trem_wrap ? '0 : cur.trem + TREM_W'(1);
                    end
                    // main pair first, then holds swap the durations across
                    if (cur.hold == '0)
                    begin
                        out_amp = amp_a_next;
                        out_dur = dur_a_next[DUR_W-1:0];
                    end
                    else if (cur.hold == HOLD_W'(1))
                    begin
                        out_amp = amp_b_next;
                        out_dur = dur_b_next[DUR_W-1:0];
                    end
                    else if (!cur.hold[0])
                    begin
                        out_amp = amp_a_next;
                        out_dur = dur_b_next[DUR_W-1:0];
                    end
                    else
                    begin
                        out_amp = amp_b_next;
                        out_dur = dur_a_next[DUR_W-1:0];
                    end
                    upd.hold = cur.hold + HOLD_W'(1);
                end
                else
                begin
                    // low step bit picks the channel
                    if (cur.step[0])
                    begin
                        amp_b_next = rp_amp_b;
                        out_amp    = rp_amp_b;
                        out_dur    = dur_b_reg[DUR_W-1:0];
                    end
                    else
                    begin
                        amp_a_next = rp_amp_a;
                        out_amp    = rp_amp_a;
                        out_dur    = dur_a_reg[DUR_W-1:0];
                    end
                    out_last = ramp_rel && (cur.step == RAMP_LAST) && (cur.rep <= REP_W'(1));
                    upd.step = cur.step + STEP_W'(1);
                end
                seq_next = settle(upd, plateau_steps_reg, hold_lim);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= '{phase: PH_IDLE, rep: '0, step: '0, hold: '0, trem: '0};
            amp_a_reg <= '0;
            amp_b_reg <= '0;
            dur_a_reg <= '0;
            dur_b_reg <= '0;
        end
        else
        begin
            seq_reg   <= seq_next;
            amp_a_reg <= amp_a_next;
            amp_b_reg <= amp_b_next;
            dur_a_reg <= dur_a_next;
            dur_b_reg <= dur_b_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic             res_valid_reg, res_valid_next;
    logic [AMP_W-1:0] res_amp_reg;
    logic [DUR_W-1:0] res_dur_reg;
    logic             res_last_reg;

    always_comb
    begin
        if (emit)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_amp_reg  <= out_amp;
            res_dur_reg  <= out_dur;
            res_last_reg <= out_last;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.amplitude = res_amp_reg;
    assign res.duration  = res_dur_reg;
    assign res.last      = res_last_reg;

endmodule

`default_nettype wire

FILE: hdl/tpps_checker.sv
// Port-level checker for the tremolo pulse pair sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "tremolo_pulse_pair_sequencer_defines.svh"

module tpps_checker import tpps_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [AMP_W-1:0]      amplitude,
    input logic [DUR_W-1:0]      duration,
    input logic                  last,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic                  pready,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata
);

    // a stalled result word stays
    `TPPS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)

    `TPPS_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(amplitude) && $stable(duration) && $stable(last))

    // every emitted amplitude has been through a clamp
    `TPPS_ASSERT_IMP(a_amp_range, res_valid, amplitude >= AMP_W'(16) && amplitude <= AMP_W'(239))

    // an 8-bit register read straight after its write returns the written byte
    `TPPS_ASSERT_IMP(a_cfg_readback, $past(rst_n) && $past(psel && penable && pwrite && pready) && psel && !pwrite && paddr[CFG_ADDR_W-1:2] == $past(paddr[CFG_ADDR_W-1:2]) && paddr[CFG_ADDR_W-1:2] <= REG_PLATEAU_STEPS, prdata[VAR_W-1:0] == $past(pwdata[VAR_W-1:0]))

endmodule

bind tremolo_pulse_pair_sequencer tpps_checker u_tpps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .amplitude (res.amplitude),
    .duration  (res.duration),
    .last      (res.last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire
